/* rtl/core/slm_pkg.sv */
`timescale 1ns / 1ps

package slm_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int VALUE_W        = 32;

  typedef logic [1:0] op_t;

  localparam op_t OP_LOAD_A = 2'd0;
  localparam op_t OP_LOAD_B = 2'd1;
  localparam op_t OP_MERGE  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
  } slm_cmd_t;

  typedef struct packed {
    logic empty;
    logic slot_free;
    logic last;
  } slm_sts_t;

endpackage

/* rtl/core/slm_ctrl.sv */
`timescale 1ns / 1ps

module slm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slm_pkg::op_t      in_op,
  input  slm_pkg::slm_sts_t sts,
  output slm_pkg::slm_cmd_t cmd
);
  import slm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load_a = 1'b0;
    cmd.load_b = 1'b0;
    cmd.step   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_LOAD_A: cmd.load_a = 1'b1;
            OP_LOAD_B: cmd.load_b = 1'b1;
            OP_MERGE: begin
              if (!sts.empty) begin
                state_nxt = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/slm_dp.sv */
`timescale 1ns / 1ps

module slm_dp #(
  parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [slm_pkg::VALUE_W-1:0]  in_value,
  input  slm_pkg::slm_cmd_t                   cmd,
  output slm_pkg::slm_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [slm_pkg::VALUE_W-1:0]  out_merged_value,
  output logic                                out_last_of_run
);
  import slm_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic signed [VALUE_W-1:0] mem_a [LIST_DEPTH];
  logic signed [VALUE_W-1:0] mem_b [LIST_DEPTH];
  logic signed [VALUE_W-1:0] rd_a_r;
  logic signed [VALUE_W-1:0] rd_b_r;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic [AW-1:0] ra_addr, rb_addr;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                      out_last_r;

  logic wr_a, wr_b, take_a, last;

  assign wr_a = cmd.load_a && (cnt_a_r < DEPTH_C);
  assign wr_b = cmd.load_b && (cnt_b_r < DEPTH_C);

  assign take_a = (ia_r < cnt_a_r) && ((ib_r >= cnt_b_r) || (rd_a_r <= rd_b_r));
  assign last   = ({1'b0, ia_r} + {1'b0, ib_r} + (CW + 1)'(1))
                  == ({1'b0, cnt_a_r} + {1'b0, cnt_b_r});

  assign sts.empty     = (cnt_a_r == '0) && (cnt_b_r == '0);
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.last      = last;

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    if (wr_a) begin
      cnt_a_nxt = cnt_a_r + CW'(1);
    end
    if (wr_b) begin
      cnt_b_nxt = cnt_b_r + CW'(1);
    end
    if (cmd.step) begin
      if (take_a) begin
        ia_nxt = ia_r + CW'(1);
      end else begin
        ib_nxt = ib_r + CW'(1);
      end
      if (last) begin
        ia_nxt    = '0;
        ib_nxt    = '0;
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
      end
    end
  end

  // read ports track the next pointers so the heads are ready every cycle
  assign ra_addr = (ia_nxt < DEPTH_C) ? ia_nxt[AW-1:0] : '0;
  assign rb_addr = (ib_nxt < DEPTH_C) ? ib_nxt[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[AW-1:0]] <= in_value;
    end
    rd_a_r <= mem_a[ra_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[cnt_b_r[AW-1:0]] <= in_value;
    end
    rd_b_r <= mem_b[rb_addr];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_value_r <= take_a ? rd_a_r : rd_b_r;
      out_last_r  <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_last_of_run  = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= DEPTH_C) && (cnt_b_r <= DEPTH_C))
    else $error("list count above depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ia_r <= cnt_a_r) && (ib_r <= cnt_b_r))
    else $error("read pointer past list end");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && last) |=> (cnt_a_r == '0) && (cnt_b_r == '0) && (ia_r == '0) && (ib_r == '0))
    else $error("lists not cleared after final element");

  a_step_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");
`endif

endmodule

/* rtl/core/sorted_list_merge.sv */
// Two-way merge of two ascending lists of signed 32-bit values.
// Input channel (in_valid/in_ready, in_op, in_value): op 0 appends in_value
// to list A, op 1 to list B, op 2 starts a merge; op 3 is ignored. Appends to
// a full list (LIST_DEPTH entries) are dropped.
// Output channel (out_valid/out_ready, out_merged_value, out_last_of_run):
// one request per merged element, ascending, A first on ties; the final
// element carries out_last_of_run. Both lists are empty afterwards.
// A taken merge request moves the controller into its merge state; each step
// there registers one element in the output register, one element per cycle
// while out_ready is high. The merge uses a single comparator and one read
// port per list. A merge with both lists empty emits nothing.
// in_ready is low while a merge runs. A stall on out_ready holds the output
// register and pauses the merge; loads are still taken while a finished
// element waits outside a merge.
// Reset (rst_n, synchronous) empties both lists and drops any pending output.
`timescale 1ns / 1ps

module sorted_list_merge #(
  parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  slm_pkg::op_t                        in_op,
  input  logic signed [slm_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [slm_pkg::VALUE_W-1:0]  out_merged_value,
  output logic                                out_last_of_run
);
  import slm_pkg::*;

  slm_cmd_t cmd;
  slm_sts_t sts;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  slm_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_merged_value (out_merged_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

/* test/sorted_list_merge_test.sv */
`timescale 1ns / 1ps

module sorted_list_merge_test;
  import slm_pkg::*;

  localparam int  DEPTH     = LIST_DEPTH_DEF;
  localparam op_t OP_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } merged_elem_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  op_t                        in_op = OP_LOAD_A;
  logic signed [VALUE_W-1:0]  in_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [VALUE_W-1:0]  out_merged_value;
  logic                       out_last_of_run;

  logic signed [VALUE_W-1:0]  list_a_copy [DEPTH];
  logic signed [VALUE_W-1:0]  list_b_copy [DEPTH];
  int                         fill_a = 0;
  int                         fill_b = 0;
  merged_elem_t               merged_q [$];

  bit idle_on = 1'b1;
  int errors = 0;
  int requests_taken = 0;
  int elems_checked = 0;
  int merges_run = 0;
  int loads_dropped = 0;

  sorted_list_merge uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_merged_value (out_merged_value),
    .out_last_of_run  (out_last_of_run)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (idle_on) begin
      out_ready <= ($urandom_range(99) >= 33);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // track loads (appends to a full list are dropped); on a merge walk both lists, A wins ties
  function void predict_request(op_t op, logic signed [VALUE_W-1:0] value);
    int ia;
    int ib;
    int total;
    merged_elem_t e;
    case (op)
      OP_LOAD_A: begin
        if (fill_a < DEPTH) begin
          list_a_copy[fill_a] = value;
          fill_a++;
        end else begin
          loads_dropped++;
        end
      end
      OP_LOAD_B: begin
        if (fill_b < DEPTH) begin
          list_b_copy[fill_b] = value;
          fill_b++;
        end else begin
          loads_dropped++;
        end
      end
      OP_MERGE: begin
        ia = 0;
        ib = 0;
        total = fill_a + fill_b;
        merges_run++;
        while (ia + ib < total) begin
          if (ib >= fill_b || (ia < fill_a && list_a_copy[ia] <= list_b_copy[ib])) begin
            e.value = list_a_copy[ia];
            ia++;
          end else begin
            e.value = list_b_copy[ib];
            ib++;
          end
          e.last = (ia + ib == total);
          merged_q.push_back(e);
        end
        fill_a = 0;
        fill_b = 0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (merged_q.size() == 0) begin
        $display("%0t: unexpected element: expected none, actual value %0d last %0b",
                 $time, out_merged_value, out_last_of_run);
        errors++;
      end else begin
        if (out_merged_value !== merged_q[0].value) begin
          $display("%0t: merged_value mismatch: expected %0d, actual %0d",
                   $time, merged_q[0].value, out_merged_value);
          errors++;
        end
        if (out_last_of_run !== merged_q[0].last) begin
          $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                   $time, merged_q[0].last, out_last_of_run);
          errors++;
        end
        void'(merged_q.pop_front());
        elems_checked++;
      end
    end
  end

  task automatic send_request(input op_t op, input logic signed [VALUE_W-1:0] value);
    if (idle_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      in_op    <= op_t'($urandom_range(3));
      in_value <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(op, value);
    if (op != OP_UNUSED) requests_taken++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_request(OP_LOAD_A, VAL_MIN);
    send_request(OP_LOAD_B, VAL_MIN);
    send_request(OP_LOAD_A, -1);
    send_request(OP_LOAD_B, 0);
    send_request(OP_LOAD_A, 0);
    send_request(OP_LOAD_B, 5);
    send_request(OP_LOAD_A, VAL_MAX);
    send_request(OP_LOAD_B, VAL_MAX);
    send_request(OP_MERGE, '0);
  endtask

  task automatic test_empty_and_unused();
    send_request(OP_MERGE, $urandom);
    send_request(OP_UNUSED, VAL_MAX);
    send_request(OP_MERGE, '0);
  endtask

  task automatic test_single_lists();
    send_request(OP_LOAD_A, 32'sd1234);
    send_request(OP_MERGE, '0);
    send_request(OP_LOAD_B, -32'sd77);
    send_request(OP_MERGE, VAL_MIN);
  endtask

  task automatic test_unsorted_walk();
    send_request(OP_LOAD_A, 32'sd5);
    send_request(OP_LOAD_A, 32'sd1);
    send_request(OP_LOAD_B, 32'sd3);
    send_request(OP_MERGE, '0);
  endtask

  // random list pairs: mostly ascending, some overfull, some empty, some out of order
  task automatic test_random_merges();
    logic signed [VALUE_W-1:0] pend_a [$];
    logic signed [VALUE_W-1:0] pend_b [$];
    longint acc;
    int span;
    int n;
    int r;
    int set_no;
    int made;
    bit ordered;
    made = 0;
    set_no = 0;
    while (made < 300) begin
      idle_on = !(set_no >= 8 && set_no < 18);
      if (set_no == 24) wait_drained();
      ordered = ($urandom_range(99) >= 10);
      case ($urandom_range(2))
        0: span = 3;
        1: span = 1000;
        default: span = 1 << 24;
      endcase
      for (int which = 0; which < 2; which++) begin
        r = $urandom_range(99);
        if (r < 8) n = $urandom_range(DEPTH - 1, DEPTH + 4);
        else if (r < 15) n = 0;
        else n = $urandom_range(1, 6);
        acc = ($urandom_range(3) == 0) ? longint'(VAL_MIN) : longint'($signed($urandom));
        for (int i = 0; i < n; i++) begin
          if (!ordered) acc = longint'($signed($urandom));
          if (which == 0) pend_a.push_back(acc[VALUE_W-1:0]);
          else pend_b.push_back(acc[VALUE_W-1:0]);
          acc = acc + $urandom_range(0, span);
          if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);
        end
      end
      while (pend_a.size() != 0 || pend_b.size() != 0) begin
        if ($urandom_range(99) < 5) send_request(OP_UNUSED, $urandom);
        if (pend_b.size() == 0 || (pend_a.size() != 0 && $urandom_range(1) == 0)) begin
          send_request(OP_LOAD_A, pend_a.pop_front());
        end else begin
          send_request(OP_LOAD_B, pend_b.pop_front());
        end
        made++;
      end
      send_request(OP_MERGE, $urandom);
      made++;
      set_no++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_empty_and_unused();
    test_single_lists();
    test_unsorted_walk();
    test_random_merges();
    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d requests, %0d merges, %0d merged elements checked",
             requests_taken, merges_run, elems_checked);
    $display("full-list drops %0d, plus empty merges, ties and out-of-order lists",
             loads_dropped);
    if (errors == 0) begin
      $display("sorted_list_merge_test: clean");
    end else begin
      $display("sorted_list_merge_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d elements still pending", merged_q.size());
    $display("sorted_list_merge_test: errors");
    $finish;
  end

endmodule
